[src/address_range_validity_checker_unit_macros.svh]
// assertion macros for the address range validity checker
// used by the top level; expects clk_i and rst_ni in scope
`ifndef ADDRESS_RANGE_VALIDITY_CHECKER_UNIT_MACROS_SVH
`define ADDRESS_RANGE_VALIDITY_CHECKER_UNIT_MACROS_SVH

// same-cycle implication
`define ARVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arvc assertion failed");

// next-cycle implication
`define ARVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arvc assertion failed");

`endif

[src/arvc_pkg.sv]
// shared types, constants and helpers for the address range validity checker
// no dependencies
`default_nettype none

package arvc_pkg;

  localparam int unsigned MaxRegionsDefault = 32;
  localparam logic [7:0]  PageMask          = 8'hFF;
  localparam logic [31:0] SpecialAddr       = 32'd4;
  localparam logic [31:0] SpecialMaxLen     = 32'd4;
  localparam int unsigned PageW             = 24;
  localparam int unsigned HeldW             = 6;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_REARM = 2'd3
  } func_e;

  typedef struct packed {
    logic [PageW-1:0] start_page;
    logic [PageW-1:0] end_page;
  } region_t;

  // region covers start_page:00 through end_page:ff
  function automatic logic in_region(input logic [31:0] a, input region_t r);
    logic [PageW-1:0] pg;
    pg = a[31:8];
    return (pg >= r.start_page) && (pg <= r.end_page);
  endfunction

endpackage

`default_nettype wire

[src/arvc_if.sv]
// request and response channel interfaces for the range checker
// depends on arvc_pkg
`default_nettype none

interface arvc_req_if import arvc_pkg::*; ();
  logic        valid;
  logic        ready;
  func_e       func;
  logic [31:0] address;
  logic [31:0] length;

  modport source (output valid, func, address, length, input ready);
  modport sink   (input valid, func, address, length, output ready);
endinterface

interface arvc_rsp_if import arvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [31:0]      first_invalid_address;
  logic             capture_armed;
  logic [HeldW-1:0] regions_held;
  logic             table_present;

  modport source (output valid, ok, first_invalid_address, capture_armed, regions_held,
                  table_present, input ready);
  modport sink   (input valid, ok, first_invalid_address, capture_armed, regions_held,
                  table_present, output ready);
endinterface

`default_nettype wire

[src/address_range_validity_checker_unit.sv]
// address range validity checker, top level
// clear, add and rearm: result loaded from S_DONE; next transfer taken once back in S_IDLE
// check: steps through S_SCAN, S_EVAL and S_DONE, one stored region compared per cycle on the read port
//   (S_SCAN skipped when empty, S_SCAN and S_EVAL when absent or a short access at four); untaken results stall input
// reset: table absent and empty, capture armed, captured address zero; no clearing pass
// depends on arvc_pkg, arvc_if, arvc_region_mem and the macros header
`default_nettype none

`include "address_range_validity_checker_unit_macros.svh"

module address_range_validity_checker_unit import arvc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = MaxRegionsDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  arvc_req_if.sink    req_i,
  arvc_rsp_if.source  rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              table_valid_q, table_valid_d;
  logic              armed_q, armed_d;
  logic [31:0]       captured_q, captured_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [31:0]       addr_a_q, addr_a_d;
  logic [31:0]       addr_b_q, addr_b_d;
  logic              hit_a_q, hit_a_d;
  logic              hit_b_q, hit_b_d;
  logic              res_ok_q, res_ok_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_load;

  logic              ok_q;
  logic [31:0]       fia_q;
  logic              armed_out_q;
  logic [HeldW-1:0]  held_q;
  logic              present_q;

  logic              req_fire;
  logic              mem_we;
  logic [IdxW-1:0]   mem_raddr;
  region_t           mem_wdata;
  region_t           mem_rdata;
  logic [31:0]       end_sum;
  logic [31:0]       last_byte;
  logic              scan_last;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // end rounded up to the page, then minus one byte, all with 32-bit wrap
  assign end_sum              = req_i.address + req_i.length + {24'd0, PageMask};
  assign mem_wdata.start_page = req_i.address[31:8];
  assign mem_wdata.end_page   = end_sum[31:8] - 24'd1;
  assign last_byte            = req_i.address + req_i.length - 32'd1;

  assign scan_last = ((CntW'(cmp_idx_q) + CntW'(1)) == count_q);
  assign mem_raddr = (state_q == S_SCAN) ? (cmp_idx_q + IdxW'(1)) : '0;

  arvc_region_mem #(
    .Depth (MAX_REGIONS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    table_valid_d = table_valid_q;
    armed_d       = armed_q;
    captured_d    = captured_q;
    cmp_idx_d     = cmp_idx_q;
    addr_a_d      = addr_a_q;
    addr_b_d      = addr_b_q;
    hit_a_d       = hit_a_q;
    hit_b_d       = hit_b_q;
    res_ok_d      = res_ok_q;
    rsp_valid_d   = rsp_valid_q;
    rsp_load      = 1'b0;
    mem_we        = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_ok_d = 1'b1;
          state_d  = S_DONE;
          unique case (req_i.func)
            FUNC_CLEAR: begin
              count_d       = '0;
              table_valid_d = 1'b1;
            end
            FUNC_ADD: begin
              if (table_valid_q) begin
                if (count_q == CntW'(MAX_REGIONS)) begin
                  // full table is dropped
                  count_d       = '0;
                  table_valid_d = 1'b0;
                end else begin
                  mem_we  = 1'b1;
                  count_d = count_q + CntW'(1);
                end
              end
            end
            FUNC_CHECK: begin
              addr_a_d  = req_i.address;
              addr_b_d  = last_byte;
              hit_a_d   = (req_i.address == SpecialAddr);
              hit_b_d   = (last_byte == SpecialAddr);
              cmp_idx_d = '0;
              if (!table_valid_q ||
                  (req_i.address == SpecialAddr && req_i.length <= SpecialMaxLen)) begin
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_EVAL;
              end else begin
                state_d = S_SCAN;
              end
            end
            FUNC_REARM: begin
              armed_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        hit_a_d = hit_a_q | in_region(addr_a_q, mem_rdata);
        hit_b_d = hit_b_q | in_region(addr_b_q, mem_rdata);
        if (scan_last) begin
          state_d = S_EVAL;
        end else begin
          cmp_idx_d = cmp_idx_q + IdxW'(1);
        end
      end
      S_EVAL: begin
        res_ok_d = hit_a_q && hit_b_q;
        // first byte is tested first, so it wins the capture
        if (armed_q && !(hit_a_q && hit_b_q)) begin
          armed_d    = 1'b0;
          captured_d = hit_a_q ? addr_b_q : addr_a_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      table_valid_q <= 1'b0;
      armed_q       <= 1'b1;
      captured_q    <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      table_valid_q <= table_valid_d;
      armed_q       <= armed_d;
      captured_q    <= captured_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    addr_a_q  <= addr_a_d;
    addr_b_q  <= addr_b_d;
    hit_a_q   <= hit_a_d;
    hit_b_q   <= hit_b_d;
    res_ok_q  <= res_ok_d;
    if (rsp_load) begin
      ok_q        <= res_ok_q;
      fia_q       <= captured_q;
      armed_out_q <= armed_q;
      held_q      <= HeldW'(count_q);
      present_q   <= table_valid_q;
    end
  end

  assign rsp_o.valid                 = rsp_valid_q;
  assign rsp_o.ok                    = ok_q;
  assign rsp_o.first_invalid_address = fia_q;
  assign rsp_o.capture_armed         = armed_out_q;
  assign rsp_o.regions_held          = held_q;
  assign rsp_o.table_present         = present_q;

  `ARVC_ASSERT_NOW(a_absent_empty, !table_valid_q, count_q == '0)
  `ARVC_ASSERT_NOW(a_scan_in_range, state_q == S_SCAN, CntW'(cmp_idx_q) < count_q)
  `ARVC_ASSERT_NEXT(a_miss_disarms, state_q == S_EVAL && !(hit_a_q && hit_b_q), !armed_q)
  `ARVC_ASSERT_NEXT(a_load_shows, state_q == S_DONE && (!rsp_valid_q || rsp_o.ready),
                    rsp_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire

[src/arvc_region_mem.sv]
// region table storage: one write port, one registered read port
// depends on arvc_pkg
`default_nettype none

module arvc_region_mem import arvc_pkg::*; #(
  parameter int unsigned Depth = MaxRegionsDefault,
  parameter int unsigned AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire region_t          wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output region_t               rdata_o
);

  region_t mem [Depth];
  region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
